FILE: rtl/core/tneq_pkg.sv
package tneq_pkg;

  // default number of note slots
  localparam int unsigned DefQueueDepth = 16;

  // field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned CHAN_W = 5;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned OCC_W  = 5;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_PROCESS = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // result event kinds
  typedef enum logic [KIND_W-1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_NONE     = 2'd2
  } event_e;

  // stored note payload of one slot
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [VEL_W-1:0]  vel;
    logic [NOTE_W-1:0] note;
  } note_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // latch the accepted beat
    logic scan_init;  // reset scan index, hit mask and hit count
    logic add_exec;   // store the note and emit the add acknowledge
    logic ack;        // emit a plain acknowledge
    logic wipe;       // empty the table and zero the last position
    logic rd_issue;   // read the slot at the scan index and advance
    logic rd_emit;    // the issued read belongs to the emit pass
    logic commit;     // apply the marked slots to the table state
    logic idx_clr;    // restart the scan index for the emit pass
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_same;   // song position equals the last processed one
    logic idx_last;   // scan index points at the final slot
    logic no_hits;    // the mark pass found no slot
  } dp_sts_t;

endpackage

FILE: rtl/core/tneq_dpath.sv
module tneq_dpath import tneq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [NOTE_W-1:0] note_number_i,
  input  logic [VEL_W-1:0]  note_velocity_i,
  input  logic [CHAN_W-1:0] note_channel_i,
  input  logic [TIME_W-1:0] due_time_i,
  input  logic [TIME_W-1:0] song_position_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] event_kind_o,
  output logic [NOTE_W-1:0] out_note_o,
  output logic [VEL_W-1:0]  out_velocity_o,
  output logic [CHAN_W-1:0] out_channel_o,
  output logic [OCC_W-1:0]  occupancy_o,
  output logic              add_dropped_o,
  output logic              last_result_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // latched beat
  cmd_e              cmd_q;
  note_t             note_q;
  logic [TIME_W-1:0] due_q;
  logic [TIME_W-1:0] pos_q;

  // table state
  logic [TIME_W-1:0]      due_mem  [QUEUE_DEPTH];
  note_t                  note_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [CntW-1:0]        occ_q;
  logic [TIME_W-1:0]      last_pos_q;

  // scan state
  logic [IdxW-1:0]        idx_q;
  logic [QUEUE_DEPTH-1:0] mask_q;
  logic [CntW-1:0]        hits_q;
  logic [CntW-1:0]        rem_q;
  logic                   p1_q;
  logic                   p1_emit_q;
  logic [IdxW-1:0]        p1_idx_q;
  logic [TIME_W-1:0]      rd_due_q;
  note_t                  rd_note_q;
  logic                   rd_vld_q;

  // result registers
  logic              res_valid_q;
  event_e            kind_q;
  note_t             res_note_q;
  logic [OCC_W-1:0]  res_occ_q;
  logic              dropped_q;
  logic              last_q;

  logic [QUEUE_DEPTH-1:0] free_vec;
  logic [QUEUE_DEPTH-1:0] first_oh;
  logic [IdxW-1:0]        free_idx;
  logic                   add_ok;
  logic                   hit_mark;
  logic                   hit_emit;
  logic                   mark_cond;

  // first empty slot, isolated as the lowest set bit of the free vector
  assign free_vec = ~valid_q;
  assign first_oh = free_vec & (~free_vec + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first_oh[i]) begin
        free_idx = free_idx | IdxW'(i);
      end
    end
  end

  assign add_ok = (due_q != '0) && !(&valid_q);

  // slot selection during the mark pass
  always_comb begin
    if (cmd_q == CMD_STOP) begin
      mark_cond = (rd_note_q.vel == '0);
    end else begin
      mark_cond = (rd_due_q <= pos_q);
    end
  end

  assign hit_mark = p1_q && !p1_emit_q && rd_vld_q && mark_cond;
  assign hit_emit = p1_q && p1_emit_q && mask_q[p1_idx_q];

  // status to the controller
  assign sts_o.pos_same = (pos_q == last_pos_q);
  assign sts_o.idx_last = (idx_q == IdxW'(QUEUE_DEPTH - 1));
  assign sts_o.no_hits  = (hits_q == '0);

  // beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      note_q <= '{chan: note_channel_i, vel: note_velocity_i, note: note_number_i};
      due_q  <= due_time_i;
      pos_q  <= song_position_i;
    end
  end

  // slot memories, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_exec && add_ok) begin
      due_mem[free_idx]  <= due_q;
      note_mem[free_idx] <= note_q;
    end
    if (cmd_i.rd_issue) begin
      rd_due_q  <= due_mem[idx_q];
      rd_note_q <= note_mem[idx_q];
      rd_vld_q  <= valid_q[idx_q];
    end
    p1_idx_q <= idx_q;
  end

  // table and scan control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      occ_q      <= '0;
      last_pos_q <= '0;
      idx_q      <= '0;
      mask_q     <= '0;
      hits_q     <= '0;
      rem_q      <= '0;
      p1_q       <= 1'b0;
      p1_emit_q  <= 1'b0;
    end else begin
      p1_q      <= cmd_i.rd_issue;
      p1_emit_q <= cmd_i.rd_emit;

      if (cmd_i.scan_init) begin
        idx_q  <= '0;
        mask_q <= '0;
        hits_q <= '0;
      end else if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.rd_issue) begin
        idx_q <= idx_q + 1'b1;
      end

      if (hit_mark) begin
        mask_q[p1_idx_q] <= 1'b1;
        hits_q           <= hits_q + 1'b1;
      end

      if (hit_emit) begin
        rem_q <= rem_q - 1'b1;
      end

      if (cmd_i.add_exec && add_ok) begin
        valid_q[free_idx] <= 1'b1;
        occ_q             <= occ_q + 1'b1;
      end

      if (cmd_i.wipe) begin
        valid_q    <= '0;
        occ_q      <= '0;
        last_pos_q <= '0;
      end

      if (cmd_i.commit) begin
        rem_q <= hits_q;
        if (cmd_q == CMD_STOP) begin
          valid_q    <= '0;
          occ_q      <= '0;
          last_pos_q <= '0;
        end else begin
          valid_q    <= valid_q & ~mask_q;
          occ_q      <= occ_q - hits_q;
          last_pos_q <= pos_q;
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.add_exec || cmd_i.ack || hit_emit;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_exec) begin
      kind_q     <= EV_NONE;
      res_note_q <= '0;
      res_occ_q  <= add_ok ? OCC_W'(occ_q + 1'b1) : OCC_W'(occ_q);
      dropped_q  <= !add_ok;
      last_q     <= 1'b1;
    end else if (cmd_i.ack) begin
      kind_q     <= EV_NONE;
      res_note_q <= '0;
      res_occ_q  <= OCC_W'(occ_q);
      dropped_q  <= 1'b0;
      last_q     <= 1'b1;
    end else if (hit_emit) begin
      kind_q     <= (rd_note_q.vel != '0) ? EV_NOTE_ON : EV_NOTE_OFF;
      res_note_q <= rd_note_q;
      res_occ_q  <= OCC_W'(occ_q);
      dropped_q  <= 1'b0;
      last_q     <= (rem_q == CntW'(1));
    end
  end

  assign result_valid_o = res_valid_q;
  assign event_kind_o   = kind_q;
  assign out_note_o     = res_note_q.note;
  assign out_velocity_o = res_note_q.vel;
  assign out_channel_o  = res_note_q.chan;
  assign occupancy_o    = res_occ_q;
  assign add_dropped_o  = dropped_q;
  assign last_result_o  = last_q;

  // occupancy counter tracks the slot valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy counter out of step with valid bits");

  // an emitted event always has a remaining count to consume
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_emit |-> (rem_q != '0))
    else $error("emit pass produced more events than were marked");

  // a dropped add is reported only on an acknowledge beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && dropped_q) |-> (kind_q == EV_NONE))
    else $error("drop flag on an event beat");

  // the mark pass only marks occupied slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> ((mask_q & ~valid_q) == '0))
    else $error("marked slot is empty at commit");

endmodule

FILE: rtl/core/tneq_ctrl.sv
module tneq_ctrl import tneq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] command_i,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o,
  output logic             busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_CLEAR,
    S_CHECK,
    S_MARK,
    S_MARK_TAIL,
    S_COMMIT,
    S_EMIT,
    S_EMIT_TAIL,
    S_ACK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_init = 1'b1;
          case (cmd_e'(command_i))
            CMD_ADD:     state_d = S_ADD;
            CMD_PROCESS: state_d = S_CHECK;
            CMD_STOP:    state_d = S_MARK;
            CMD_CLEAR:   state_d = S_CLEAR;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add_exec = 1'b1;
        state_d        = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.wipe = 1'b1;
        state_d    = S_ACK;
      end
      S_CHECK: begin
        state_d = sts_i.pos_same ? S_ACK : S_MARK;
      end
      S_MARK: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_MARK_TAIL;
        end
      end
      S_MARK_TAIL: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit  = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = sts_i.no_hits ? S_ACK : S_EMIT;
      end
      S_EMIT: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.rd_emit  = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_EMIT_TAIL;
        end
      end
      S_EMIT_TAIL: begin
        state_d = S_IDLE;
      end
      S_ACK: begin
        cmd_o.ack = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    busy_d = (state_d != S_IDLE);
  end

  // state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

  // busy flag mirrors a non-idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != S_IDLE))
    else $error("busy flag out of step with state");

  // an accepted beat always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q) |=> busy_q)
    else $error("accepted beat did not start work");

  // the commit step is always preceded by the drain of the mark pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> ($past(state_q) == S_MARK_TAIL))
    else $error("commit without a finished mark pass");

endmodule

FILE: rtl/core/timed_note_event_queue.sv
// Timed note event queue: a table of QUEUE_DEPTH note slots with a due time each. A command
// beat is taken when start is high and busy is low; the block answers with one or more result
// beats, each shown for a single cycle on result_valid_o, the final one of a command carrying
// last_result_o. The receiver cannot stall, so it must take every beat as it appears. Add,
// clear and a process at the same song position answer with a single acknowledge. Process
// and stop scan the table twice through the single slot memory read port, one slot a cycle:
// a mark pass that finds the due (or zero-velocity) slots and counts them, so every beat can
// report the final occupancy, then an emit pass that sends the events in slot order. When
// the mark pass finds no slot, the emit pass is skipped for a single acknowledge. The final
// beat of every command appears by the first cycle after busy falls; an emit pass can send
// it earlier, while busy is still high.
module timed_note_event_queue import tneq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [NOTE_W-1:0] note_number_i,
  input  logic [VEL_W-1:0]  note_velocity_i,
  input  logic [CHAN_W-1:0] note_channel_i,
  input  logic [TIME_W-1:0] due_time_i,
  input  logic [TIME_W-1:0] song_position_i,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] event_kind_o,
  output logic [NOTE_W-1:0] out_note_o,
  output logic [VEL_W-1:0]  out_velocity_o,
  output logic [CHAN_W-1:0] out_channel_o,
  output logic [OCC_W-1:0]  occupancy_o,
  output logic              add_dropped_o,
  output logic              last_result_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // command sequencer
  tneq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd),
    .busy      (busy)
  );

  // slot table, scan and result registers
  tneq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .note_number_i   (note_number_i),
    .note_velocity_i (note_velocity_i),
    .note_channel_i  (note_channel_i),
    .due_time_i      (due_time_i),
    .song_position_i (song_position_i),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .result_valid_o  (result_valid_o),
    .event_kind_o    (event_kind_o),
    .out_note_o      (out_note_o),
    .out_velocity_o  (out_velocity_o),
    .out_channel_o   (out_channel_o),
    .occupancy_o     (occupancy_o),
    .add_dropped_o   (add_dropped_o),
    .last_result_o   (last_result_o)
  );

endmodule

FILE: bench/timed_note_event_queue_tb.sv
`timescale 1ns / 1ps

module timed_note_event_queue_tb;
  import tneq_pkg::*;

  localparam int unsigned SLOTS = DefQueueDepth;
  // longest busy stretch of one command plus the trailing result beat and margin
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;

  // one expected result beat
  typedef struct {
    event_e            kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [CHAN_W-1:0] chan;
    logic [OCC_W-1:0]  occ;
    logic              dropped;
    logic              last;
  } event_rec_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  command_i = '0;
  logic [NOTE_W-1:0] note_number_i = '0;
  logic [VEL_W-1:0]  note_velocity_i = '0;
  logic [CHAN_W-1:0] note_channel_i = '0;
  logic [TIME_W-1:0] due_time_i = '0;
  logic [TIME_W-1:0] song_position_i = '0;
  logic              result_valid_o;
  logic [KIND_W-1:0] event_kind_o;
  logic [NOTE_W-1:0] out_note_o;
  logic [VEL_W-1:0]  out_velocity_o;
  logic [CHAN_W-1:0] out_channel_o;
  logic [OCC_W-1:0]  occupancy_o;
  logic              add_dropped_o;
  logic              last_result_o;

  // scheduler image kept by the bench
  logic [TIME_W-1:0] sched_due [SLOTS];
  note_t             sched_note [SLOTS];
  logic [TIME_W-1:0] sched_last_pos;

  event_rec_t expected_events[$];
  event_rec_t head_event;
  int         fail_cnt = 0;
  bit         idle_enable = 1'b1;
  logic [TIME_W-1:0] song_pos = 32'd100;

  timed_note_event_queue #(
    .QUEUE_DEPTH(SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .note_number_i  (note_number_i),
    .note_velocity_i(note_velocity_i),
    .note_channel_i (note_channel_i),
    .due_time_i     (due_time_i),
    .song_position_i(song_position_i),
    .result_valid_o (result_valid_o),
    .event_kind_o   (event_kind_o),
    .out_note_o     (out_note_o),
    .out_velocity_o (out_velocity_o),
    .out_channel_o  (out_channel_o),
    .occupancy_o    (occupancy_o),
    .add_dropped_o  (add_dropped_o),
    .last_result_o  (last_result_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // empty every slot and forget the last position
  task automatic wipe_schedule();
    for (int i = 0; i < SLOTS; i++) begin
      sched_due[i]  = '0;
      sched_note[i] = '0;
    end
    sched_last_pos = '0;
  endtask

  // work out the result beats of one accepted command
  task automatic predict_command(input cmd_e cmd, input note_t nd,
                                 input logic [TIME_W-1:0] due,
                                 input logic [TIME_W-1:0] pos);
    event_rec_t batch[$];
    event_rec_t ev;
    bit         stored;
    int         occ;
    stored = 1'b0;
    occ = 0;
    case (cmd)
      CMD_ADD: begin
        if (due != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!stored && sched_due[i] == '0) begin
              sched_due[i]  = due;
              sched_note[i] = nd;
              stored = 1'b1;
            end
          end
        end
        ev = '{EV_NONE, '0, '0, '0, '0, !stored, 1'b0};
        batch.push_back(ev);
      end
      CMD_PROCESS: begin
        if (pos != sched_last_pos) begin
          sched_last_pos = pos;
          for (int i = 0; i < SLOTS; i++) begin
            if (sched_due[i] != '0 && sched_due[i] <= pos) begin
              ev = '{(sched_note[i].vel != '0) ? EV_NOTE_ON : EV_NOTE_OFF,
                     sched_note[i].note, sched_note[i].vel, sched_note[i].chan,
                     '0, 1'b0, 1'b0};
              batch.push_back(ev);
              sched_due[i]  = '0;
              sched_note[i] = '0;
            end
          end
        end
      end
      CMD_STOP: begin
        // pending note-offs are flushed before the wipe
        for (int i = 0; i < SLOTS; i++) begin
          if (sched_due[i] != '0 && sched_note[i].vel == '0) begin
            ev = '{EV_NOTE_OFF, sched_note[i].note, sched_note[i].vel,
                   sched_note[i].chan, '0, 1'b0, 1'b0};
            batch.push_back(ev);
          end
        end
        wipe_schedule();
      end
      default: wipe_schedule();
    endcase
    if (batch.size() == 0) begin
      ev = '{EV_NONE, '0, '0, '0, '0, 1'b0, 1'b0};
      batch.push_back(ev);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (sched_due[i] != '0) occ++;
    end
    foreach (batch[i]) begin
      batch[i].occ = occ[OCC_W-1:0];
      batch[i].last = (i == batch.size() - 1);
      expected_events.push_back(batch[i]);
    end
  endtask

  // send one command beat; start stays high on return
  task automatic issue_command(input cmd_e cmd, input logic [NOTE_W-1:0] note,
                               input logic [VEL_W-1:0] vel,
                               input logic [CHAN_W-1:0] chan,
                               input logic [TIME_W-1:0] due,
                               input logic [TIME_W-1:0] pos);
    note_t nd;
    int    gap;
    nd = '{chan: chan, vel: vel, note: note};
    if (idle_enable && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    note_number_i   <= note;
    note_velocity_i <= vel;
    note_channel_i  <= chan;
    due_time_i      <= due;
    song_position_i <= pos;
    do @(posedge clk_i); while (busy);
    predict_command(cmd, nd, due, pos);
  endtask

  // check every result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_events.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result beat: kind=%0d note=%0d at %0t",
                   event_kind_o, out_note_o, $realtime);
      end else begin
        head_event = expected_events.pop_front();
        if (event_kind_o !== head_event.kind || out_note_o !== head_event.note ||
            out_velocity_o !== head_event.vel || out_channel_o !== head_event.chan ||
            occupancy_o !== head_event.occ || add_dropped_o !== head_event.dropped ||
            last_result_o !== head_event.last) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch at %0t: expected kind=%0d note=%0d vel=%0d chan=%0d occ=%0d drop=%0b last=%0b",
                     $realtime, head_event.kind, head_event.note, head_event.vel,
                     head_event.chan, head_event.occ, head_event.dropped, head_event.last);
            $display("            actual   kind=%0d note=%0d vel=%0d chan=%0d occ=%0d drop=%0b last=%0b",
                     event_kind_o, out_note_o, out_velocity_o, out_channel_o,
                     occupancy_o, add_dropped_o, last_result_o);
          end
        end
      end
    end
  end

  // adds at the field extremes, a zero due time, repeated and far positions
  task automatic test_add_and_fire();
    issue_command(CMD_ADD, 7'd127, 7'd127, 5'd31, 32'd1, '0);
    issue_command(CMD_ADD, 7'd0, 7'd0, 5'd0, 32'hFFFF_FFFF, '0);
    issue_command(CMD_ADD, 7'd64, 7'd10, 5'd16, 32'd0, '0);
    issue_command(CMD_PROCESS, '0, '0, '0, '0, 32'd0);
    issue_command(CMD_PROCESS, '0, '0, '0, '0, 32'd1);
    issue_command(CMD_PROCESS, '0, '0, '0, '0, 32'd1);
    issue_command(CMD_PROCESS, '0, '0, '0, '0, 32'hFFFF_FFFF);
  endtask

  // fill every slot, overflow once, then stop with mixed velocities
  task automatic test_full_table();
    issue_command(CMD_CLEAR, '0, '0, '0, '0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      issue_command(CMD_ADD, 7'(i * 8 + 3), (i % 3 == 0) ? 7'd0 : 7'(i * 7 + 1),
                    5'(i * 2 + 1), 32'($urandom_range(1, 50)), '0);
    end
    issue_command(CMD_ADD, 7'd5, 7'd5, 5'd5, 32'd9, '0);
    issue_command(CMD_STOP, '0, '0, '0, '0, '0);
    issue_command(CMD_STOP, '0, '0, '0, '0, '0);
  endtask

  // song-like traffic: adds ahead of the position, advancing processes, occasional stops and clears
  task automatic test_random_traffic(input int n_items);
    int                r;
    cmd_e              cmd;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] pos;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      due = song_pos + $urandom_range(1, 24);
      pos = song_pos;
      if (r < 55) begin
        cmd = CMD_ADD;
        r = $urandom_range(99);
        if (r < 5) due = '0;
        else if (r < 10) due = $urandom();
      end else if (r < 92) begin
        cmd = CMD_PROCESS;
        song_pos = song_pos + $urandom_range(0, 6);
        pos = ($urandom_range(99) < 5) ? $urandom() : song_pos;
      end else if (r < 97) begin
        cmd = CMD_STOP;
      end else begin
        cmd = CMD_CLEAR;
      end
      issue_command(cmd, 7'($urandom()), 7'($urandom()), 5'($urandom()), due, pos);
    end
  endtask

  // main sequence
  initial begin
    wipe_schedule();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_add_and_fire();
    test_full_table();
    test_random_traffic(75);
    idle_enable = 1'b0;
    test_random_traffic(50);
    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && expected_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
